### design/tmmb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmmb_pkg: shared definitions for the trimmed mean mode benchmark
// Phase codes, function codes, sample store sizing and datapath widths.
// ----------------------------------------------------------------------------
package tmmb_pkg;

	localparam int WARMUP_COUNT = 4;
	localparam int SAMPLE_COUNT = 64;
	localparam int STORE_DEPTH  = 64;
	localparam int STORE_AW     = $clog2(STORE_DEPTH);
	localparam int TRIM         = SAMPLE_COUNT / 8;
	localparam int KEEP         = SAMPLE_COUNT - 2 * TRIM;
	localparam int CNT_W        = $clog2(SAMPLE_COUNT + 1);
	localparam int RANK_W       = $clog2(SAMPLE_COUNT);

	localparam int TIME_W = 48;
	localparam int SUM_W  = TIME_W + $clog2(SAMPLE_COUNT);
	localparam int DIV_W  = 8;
	localparam int SIG_W  = 32;
	localparam int GEN_W  = 32;
	localparam int WARM_W = 8;

	localparam logic [2:0] PH_OFF   = 3'd0;
	localparam logic [2:0] PH_NWARM = 3'd1;
	localparam logic [2:0] PH_NSAMP = 3'd2;
	localparam logic [2:0] PH_PWARM = 3'd3;
	localparam logic [2:0] PH_PSAMP = 3'd4;
	localparam logic [2:0] PH_LNAT  = 3'd5;
	localparam logic [2:0] PH_LPK   = 3'd6;

	localparam logic [1:0] FN_UPDATE = 2'd0;
	localparam logic [1:0] FN_REPORT = 2'd1;
	localparam logic [1:0] FN_REJECT = 2'd2;
	localparam logic [1:0] FN_QUERY  = 2'd3;

	localparam logic CFG_FLOOR   = 1'b0;
	localparam logic CFG_DIVISOR = 1'b1;

endpackage

### design/tmmb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmmb_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/tmmb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmmb_div: serial restoring divider
// Divides a sum-wide dividend by an 8-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tmmb_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tmmb_pkg::SUM_W-1:0] dividend,
	input  logic [tmmb_pkg::DIV_W-1:0] divisor,
	output logic                      done,
	output logic [tmmb_pkg::SUM_W-1:0] quotient
);

	localparam int STEP_W = $clog2(tmmb_pkg::SUM_W);

	logic                       busy_q;
	logic                       done_q;
	logic [STEP_W-1:0]          step_q;
	logic [tmmb_pkg::DIV_W-1:0] rem_q;
	logic [tmmb_pkg::DIV_W-1:0] dvs_q;
	logic [tmmb_pkg::SUM_W-1:0] quo_q;
	logic [tmmb_pkg::DIV_W:0]   trial;
	logic                       fits;

	assign trial = {rem_q, quo_q[tmmb_pkg::SUM_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(tmmb_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? tmmb_pkg::DIV_W'(trial - {1'b0, dvs_q})
			              : trial[tmmb_pkg::DIV_W-1:0];
			quo_q <= {quo_q[tmmb_pkg::SUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### design/trimmed_mean_mode_benchmark.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_mean_mode_benchmark: native versus packed mode chooser
// Runs warmup and sampling stages for both paths, takes the trimmed mean
// of each sample set and locks in packed unless it is slower by more than the margin.
// ----------------------------------------------------------------------------
//
//   channel  handshake              payload
//   in       in_valid / in_stall    func, format_signature, eligible,
//                                   report_token, full_copy, elapsed_time,
//                                   packed_path
//   out      out_valid / out_stall  wants_packed, benchmarking,
//                                   timing_token, phase_code
//   cfg      cfg_we                 cfg_index, cfg_data
//
// An update, report, reject or query word passes through the decode and
// emit states into the output register, and the next word is taken once
// the block is back in its idle state. An update that closes a sampling
// stage also runs the rank sweep over the sample RAM: for each sample a
// capture state, then one compare a cycle. A serial division for the mean
// follows, and after the packed stage a second serial division for the
// relative margin.
// The input stalls for the whole time a word is in work. A stalled output
// word is held, and the next input word may be accepted meanwhile, but it
// is not written to the output until the held word has gone.
// Reset puts the block in the disabled phase with no stored signature.
//
module trimmed_mean_mode_benchmark (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  func,
	input  logic [tmmb_pkg::SIG_W-1:0]  format_signature,
	input  logic                        eligible,
	input  logic [tmmb_pkg::GEN_W-1:0]  report_token,
	input  logic                        full_copy,
	input  logic [tmmb_pkg::TIME_W-1:0] elapsed_time,
	input  logic                        packed_path,

	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        wants_packed,
	output logic                        benchmarking,
	output logic [tmmb_pkg::GEN_W-1:0]  timing_token,
	output logic [2:0]                  phase_code,

	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [31:0]                 cfg_data
);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_CAP    = 3'd2;
	localparam logic [2:0] ST_SWEEP  = 3'd3;
	localparam logic [2:0] ST_MDIV   = 3'd4;
	localparam logic [2:0] ST_RDIV   = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;

	localparam int AW = tmmb_pkg::STORE_AW;
	localparam int TW = tmmb_pkg::TIME_W;

	logic [2:0] state_q;

	// Configuration registers.
	logic [31:0]                 floor_q;
	logic [tmmb_pkg::DIV_W-1:0]  divisor_q;

	// Architectural state.
	logic [2:0]                  phase_q;
	logic [tmmb_pkg::SIG_W-1:0]  sig_q;
	logic                        sigv_q;
	logic [tmmb_pkg::GEN_W-1:0]  gen_q;
	logic [tmmb_pkg::WARM_W-1:0] warm_q;
	logic [tmmb_pkg::CNT_W-1:0]  samp_q;
	logic [TW-1:0]               nmean_q;

	// Latched input word.
	logic [1:0]                  func_q;
	logic [tmmb_pkg::SIG_W-1:0]  fsig_q;
	logic                        elig_q;
	logic [tmmb_pkg::GEN_W-1:0]  tok_q;
	logic                        full_q;
	logic [TW-1:0]               time_q;
	logic                        pkp_q;

	// Rank sweep and mean datapath.
	logic [AW-1:0]               i_q;
	logic [tmmb_pkg::CNT_W-1:0]  k_q;
	logic [tmmb_pkg::RANK_W-1:0] rank_q;
	logic [TW-1:0]               vi_q;
	logic [tmmb_pkg::SUM_W-1:0]  total_q;
	logic [TW-1:0]               pmean_q;

	// Output register.
	logic                        ovalid_q;
	logic                        owp_q;
	logic                        obm_q;
	logic [tmmb_pkg::GEN_W-1:0]  otok_q;
	logic [2:0]                  oph_q;

	// RAM and divider hookup.
	logic                        ram_we;
	logic [AW-1:0]               ram_raddr;
	logic [TW-1:0]               ram_rdata;
	logic                        div_start;
	logic [tmmb_pkg::SUM_W-1:0]  div_dividend;
	logic [tmmb_pkg::DIV_W-1:0]  div_divisor;
	logic                        div_done;
	logic [tmmb_pkg::SUM_W-1:0]  div_quot;

	// Decode results for the latched word.
	logic [2:0]                  u_phase;
	logic [tmmb_pkg::GEN_W-1:0]  u_gen;
	logic [tmmb_pkg::WARM_W-1:0] u_warm;
	logic [tmmb_pkg::CNT_W-1:0]  u_samp;
	logic [tmmb_pkg::SIG_W-1:0]  u_sig;
	logic                        u_sigv;
	logic [TW-1:0]               u_nm;
	logic                        u_need_mean;

	// Sweep compare.
	logic                        less;
	logic [tmmb_pkg::RANK_W-1:0] rank_n;
	logic                        in_middle;
	logic                        sweep_last;

	// Final decision.
	logic [TW-1:0]               rel;
	logic [TW-1:0]               thr;
	logic                        use_pk;

	logic                        wp_now;
	logic                        bm_now;

	assign in_stall = state_q != ST_IDLE;

	// Work out what an update, report, reject or query does to the state.
	always_comb begin
		u_phase     = phase_q;
		u_gen       = gen_q;
		u_warm      = warm_q;
		u_samp      = samp_q;
		u_sig       = sig_q;
		u_sigv      = sigv_q;
		u_nm        = nmean_q;
		u_need_mean = 1'b0;
		ram_we      = 1'b0;
		case (func_q)
			tmmb_pkg::FN_UPDATE: begin
				if (!sigv_q || fsig_q != sig_q) begin
					u_sig   = fsig_q;
					u_sigv  = 1'b1;
					u_nm    = '0;
					u_phase = elig_q ? tmmb_pkg::PH_NWARM : tmmb_pkg::PH_OFF;
					u_gen   = u_gen + 1'b1;
					u_warm  = '0;
					u_samp  = '0;
				end
				if (u_phase == tmmb_pkg::PH_NWARM &&
				    u_warm >= tmmb_pkg::WARM_W'(tmmb_pkg::WARMUP_COUNT)) begin
					u_phase = tmmb_pkg::PH_NSAMP;
					u_gen   = u_gen + 1'b1;
					u_warm  = '0;
					u_samp  = '0;
				end else if (u_phase == tmmb_pkg::PH_PWARM &&
				    u_warm >= tmmb_pkg::WARM_W'(tmmb_pkg::WARMUP_COUNT)) begin
					u_phase = tmmb_pkg::PH_PSAMP;
					u_gen   = u_gen + 1'b1;
					u_warm  = '0;
					u_samp  = '0;
				end else if ((u_phase == tmmb_pkg::PH_NSAMP ||
				              u_phase == tmmb_pkg::PH_PSAMP) &&
				             u_samp >= tmmb_pkg::CNT_W'(tmmb_pkg::SAMPLE_COUNT)) begin
					u_need_mean = 1'b1;
				end
			end
			tmmb_pkg::FN_REPORT: begin
				if (tok_q == gen_q && full_q) begin
					if (phase_q == tmmb_pkg::PH_NWARM || phase_q == tmmb_pkg::PH_PWARM) begin
						if (warm_q != '1) begin
							u_warm = warm_q + 1'b1;
						end
					end else if (phase_q == tmmb_pkg::PH_NSAMP ||
					             phase_q == tmmb_pkg::PH_PSAMP) begin
						if (samp_q < tmmb_pkg::CNT_W'(tmmb_pkg::SAMPLE_COUNT)) begin
							ram_we = state_q == ST_DECODE;
							u_samp = samp_q + 1'b1;
						end
					end
				end
			end
			tmmb_pkg::FN_REJECT: begin
				if (phase_q == tmmb_pkg::PH_PWARM || phase_q == tmmb_pkg::PH_PSAMP ||
				    phase_q == tmmb_pkg::PH_LPK) begin
					u_phase = tmmb_pkg::PH_LNAT;
					u_gen   = gen_q + 1'b1;
					u_warm  = '0;
					u_samp  = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// Rank of the held sample among all samples, ties broken by position.
	assign less = ram_rdata < vi_q ||
	              (ram_rdata == vi_q && AW'(k_q - 1'b1) < i_q);
	assign rank_n     = rank_q + tmmb_pkg::RANK_W'(less);
	assign in_middle  = rank_n >= tmmb_pkg::RANK_W'(tmmb_pkg::TRIM) &&
	                    rank_n < tmmb_pkg::RANK_W'(tmmb_pkg::SAMPLE_COUNT - tmmb_pkg::TRIM);
	assign sweep_last = k_q == tmmb_pkg::CNT_W'(tmmb_pkg::SAMPLE_COUNT);

	always_comb begin
		case (state_q)
			ST_SWEEP: ram_raddr = sweep_last ? AW'(i_q + 1'b1) : k_q[AW-1:0];
			default:  ram_raddr = '0;
		endcase
	end

	// Packed wins unless it is slower than native by more than the margin.
	assign rel    = div_quot[TW-1:0];
	assign thr    = rel > TW'(floor_q) ? rel : TW'(floor_q);
	assign use_pk = pmean_q <= nmean_q || (pmean_q - nmean_q) <= thr;

	always_comb begin
		div_start    = 1'b0;
		div_dividend = total_q;
		div_divisor  = tmmb_pkg::DIV_W'(tmmb_pkg::KEEP);
		if (state_q == ST_SWEEP && sweep_last && i_q == AW'(tmmb_pkg::SAMPLE_COUNT - 1)) begin
			div_start    = 1'b1;
			div_dividend = in_middle ? total_q + tmmb_pkg::SUM_W'(vi_q) : total_q;
		end else if (state_q == ST_MDIV && div_done && phase_q == tmmb_pkg::PH_PSAMP) begin
			div_start    = 1'b1;
			div_dividend = tmmb_pkg::SUM_W'(nmean_q);
			div_divisor  = divisor_q == '0 ? tmmb_pkg::DIV_W'(1) : divisor_q;
		end
	end

	assign wp_now = phase_q == tmmb_pkg::PH_PWARM || phase_q == tmmb_pkg::PH_PSAMP ||
	                phase_q == tmmb_pkg::PH_LPK;
	assign bm_now = phase_q >= tmmb_pkg::PH_NWARM && phase_q <= tmmb_pkg::PH_PSAMP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			floor_q   <= 32'd50000;
			divisor_q <= tmmb_pkg::DIV_W'(20);
			phase_q   <= tmmb_pkg::PH_OFF;
			sig_q     <= '0;
			sigv_q    <= 1'b0;
			gen_q     <= '0;
			warm_q    <= '0;
			samp_q    <= '0;
			nmean_q   <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tmmb_pkg::CFG_FLOOR:   floor_q   <= cfg_data;
					tmmb_pkg::CFG_DIVISOR: divisor_q <= cfg_data[tmmb_pkg::DIV_W-1:0];
					default: begin
					end
				endcase
			end
			// The output register fills from the emit state and empties once
			// its word has been taken.
			if (state_q == ST_EMIT && (!ovalid_q || !out_stall)) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					phase_q <= u_phase;
					gen_q   <= u_gen;
					warm_q  <= u_warm;
					samp_q  <= u_samp;
					sig_q   <= u_sig;
					sigv_q  <= u_sigv;
					nmean_q <= u_nm;
					state_q <= u_need_mean ? ST_CAP : ST_EMIT;
				end
				ST_CAP: begin
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (sweep_last) begin
						state_q <= div_start ? ST_MDIV : ST_CAP;
					end
				end
				ST_MDIV: begin
					if (div_done) begin
						if (phase_q == tmmb_pkg::PH_PSAMP) begin
							state_q <= ST_RDIV;
						end else begin
							nmean_q <= div_quot[TW-1:0];
							phase_q <= tmmb_pkg::PH_PWARM;
							gen_q   <= gen_q + 1'b1;
							warm_q  <= '0;
							samp_q  <= '0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_RDIV: begin
					if (div_done) begin
						phase_q <= use_pk ? tmmb_pkg::PH_LPK : tmmb_pkg::PH_LNAT;
						gen_q   <= gen_q + 1'b1;
						warm_q  <= '0;
						samp_q  <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!ovalid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			func_q <= func;
			fsig_q <= format_signature;
			elig_q <= eligible;
			tok_q  <= report_token;
			full_q <= full_copy;
			time_q <= elapsed_time;
			pkp_q  <= packed_path;
		end
		if (state_q == ST_DECODE) begin
			i_q     <= '0;
			total_q <= '0;
		end
		if (state_q == ST_CAP) begin
			vi_q   <= ram_rdata;
			k_q    <= tmmb_pkg::CNT_W'(1);
			rank_q <= '0;
		end
		if (state_q == ST_SWEEP) begin
			rank_q <= rank_n;
			k_q    <= k_q + 1'b1;
			if (sweep_last) begin
				i_q <= i_q + 1'b1;
				if (in_middle) begin
					total_q <= total_q + tmmb_pkg::SUM_W'(vi_q);
				end
			end
		end
		if (state_q == ST_MDIV && div_done) begin
			pmean_q <= div_quot[TW-1:0];
		end
		if (state_q == ST_EMIT && (!ovalid_q || !out_stall)) begin
			owp_q  <= wp_now;
			obm_q  <= bm_now;
			otok_q <= (bm_now && pkp_q == wp_now) ? gen_q : '0;
			oph_q  <= phase_q;
		end
	end

	tmmb_ram #(
		.WIDTH (TW),
		.DEPTH (tmmb_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (samp_q[AW-1:0]),
		.wdata (time_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tmmb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign out_valid    = ovalid_q;
	assign wants_packed = owp_q;
	assign benchmarking = obm_q;
	assign timing_token = otok_q;
	assign phase_code   = oph_q;

endmodule

### design/tmmb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmmb_checker: port level checks for the mode chooser
// Watches the top level ports and flags inconsistent result words.
// ----------------------------------------------------------------------------
module tmmb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        wants_packed,
	input logic        benchmarking,
	input logic [31:0] timing_token,
	input logic [2:0]  phase_code
);

	// An accepted word keeps the input stalled while it is worked on.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// A stalled result word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(phase_code) &&
		$stable(timing_token))
		else $error("stalled result changed");

	// No token is handed out outside the benchmark phases.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !benchmarking |-> timing_token == 32'd0)
		else $error("token outside benchmark");

	// The flags agree with the phase code.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (wants_packed == (phase_code == tmmb_pkg::PH_PWARM ||
		phase_code == tmmb_pkg::PH_PSAMP || phase_code == tmmb_pkg::PH_LPK)) &&
		(benchmarking == (phase_code == tmmb_pkg::PH_NWARM ||
		phase_code == tmmb_pkg::PH_NSAMP || phase_code == tmmb_pkg::PH_PWARM ||
		phase_code == tmmb_pkg::PH_PSAMP)))
		else $error("flags disagree with phase");

endmodule

bind trimmed_mean_mode_benchmark tmmb_checker u_tmmb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.wants_packed (wants_packed),
	.benchmarking (benchmarking),
	.timing_token (timing_token),
	.phase_code   (phase_code)
);

### tb/trimmed_mean_mode_benchmark_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_mean_mode_benchmark_tb: self-checking bench for the mode chooser
// Drives update, report, reject and query words through the valid/stall
// channels and predicts every output word with an independent phase
// tracker. Whole benchmark runs are played under several margin settings.
// ----------------------------------------------------------------------------
module trimmed_mean_mode_benchmark_tb;
	import tmmb_pkg::*;

	typedef struct packed {
		logic              wp;
		logic              bm;
		logic [GEN_W-1:0]  tok;
		logic [2:0]        ph;
	} mode_word_t;

	// Tracks the phase machine of the block and holds the output words that
	// are still owed, oldest first.
	class mode_choice_tracker;
		logic [31:0]       floor_r;
		logic [DIV_W-1:0]  divisor_r;
		logic [2:0]        phase;
		logic [SIG_W-1:0]  sig;
		logic              sig_ok;
		logic [GEN_W-1:0]  gen;
		int unsigned       warm;
		int unsigned       nsamp;
		logic [TIME_W-1:0] nat_mean;
		logic [TIME_W-1:0] samples [64];
		mode_word_t        owed [$];
		int unsigned       errors;

		function new();
			floor_r = 32'd50000;
			divisor_r = 8'd20;
			phase = PH_OFF;
			sig = '0;
			sig_ok = 1'b0;
			gen = '0;
			warm = 0;
			nsamp = 0;
			nat_mean = '0;
			errors = 0;
			foreach (samples[i]) samples[i] = '0;
		endfunction

		function void set_reg(logic idx, logic [31:0] data);
			if (idx == CFG_FLOOR) floor_r = data;
			else divisor_r = data[DIV_W-1:0];
		endfunction

		function void next_stage(logic [2:0] p);
			phase = p;
			gen = gen + 1;
			warm = 0;
			nsamp = 0;
			foreach (samples[i]) samples[i] = '0;
		endfunction

		// Sort the sample set and average the middle three quarters.
		function logic [TIME_W-1:0] trimmed_mean();
			logic [TIME_W-1:0] s [64];
			logic [TIME_W-1:0] v;
			longint unsigned   total;
			int                j;
			total = 0;
			foreach (samples[i]) s[i] = samples[i];
			for (int i = 1; i < SAMPLE_COUNT; i++) begin
				v = s[i];
				j = i;
				while (j > 0 && s[j-1] > v) begin
					s[j] = s[j-1];
					j--;
				end
				s[j] = v;
			end
			for (int i = TRIM; i < SAMPLE_COUNT - TRIM; i++) total += s[i];
			return TIME_W'(total / KEEP);
		endfunction

		function bit packed_wanted();
			return phase == PH_PWARM || phase == PH_PSAMP || phase == PH_LPK;
		endfunction

		function void note_word(logic [1:0] fn, logic [SIG_W-1:0] fsig, logic elig,
		                        logic [GEN_W-1:0] rtok, logic full, logic [TIME_W-1:0] t,
		                        logic pp);
			mode_word_t        w;
			logic [TIME_W-1:0] pk;
			longint unsigned   rel, thr, d;
			if (fn == FN_UPDATE) begin
				if (!sig_ok || fsig != sig) begin
					sig = fsig;
					sig_ok = 1'b1;
					nat_mean = '0;
					next_stage(elig ? PH_NWARM : PH_OFF);
				end
				case (phase)
					PH_NWARM: if (warm >= WARMUP_COUNT) next_stage(PH_NSAMP);
					PH_PWARM: if (warm >= WARMUP_COUNT) next_stage(PH_PSAMP);
					PH_NSAMP: if (nsamp >= SAMPLE_COUNT) begin
						nat_mean = trimmed_mean();
						next_stage(PH_PWARM);
					end
					PH_PSAMP: if (nsamp >= SAMPLE_COUNT) begin
						pk = trimmed_mean();
						d = (divisor_r == 0) ? 1 : divisor_r;
						rel = nat_mean / d;
						thr = (rel > floor_r) ? rel : floor_r;
						// Packed wins unless its slowdown exceeds the margin.
						if (pk <= nat_mean || (pk - nat_mean) <= thr) next_stage(PH_LPK);
						else next_stage(PH_LNAT);
					end
					default: ;
				endcase
			end else if (fn == FN_REPORT) begin
				if (rtok == gen && full) begin
					if (phase == PH_NWARM || phase == PH_PWARM) begin
						if (warm < 255) warm++;
					end else if (phase == PH_NSAMP || phase == PH_PSAMP) begin
						if (nsamp < SAMPLE_COUNT) begin
							samples[nsamp] = t;
							nsamp++;
						end
					end
				end
			end else if (fn == FN_REJECT) begin
				if (packed_wanted()) next_stage(PH_LNAT);
			end
			w.wp = packed_wanted();
			w.bm = (phase >= PH_NWARM && phase <= PH_PSAMP);
			w.tok = (w.bm && pp == w.wp) ? gen : '0;
			w.ph = phase;
			owed.push_back(w);
		endfunction

		function void check_word(mode_word_t got);
			mode_word_t e;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected output word %p", got);
				return;
			end
			e = owed.pop_front();
			if (got !== e) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected wp=%0b bm=%0b tok=%0h ph=%0d, got wp=%0b bm=%0b tok=%0h ph=%0d",
					         e.wp, e.bm, e.tok, e.ph, got.wp, got.bm, got.tok, got.ph);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        func;
	logic [SIG_W-1:0]  format_signature;
	logic              eligible;
	logic [GEN_W-1:0]  report_token;
	logic              full_copy;
	logic [TIME_W-1:0] elapsed_time;
	logic              packed_path;
	logic              out_valid;
	logic              out_stall;
	logic              wants_packed;
	logic              benchmarking;
	logic [GEN_W-1:0]  timing_token;
	logic [2:0]        phase_code;
	logic              cfg_we;
	logic              cfg_index;
	logic [31:0]       cfg_data;

	mode_choice_tracker tracker;
	bit                 hold_req;
	bit                 idle_gaps;

	trimmed_mean_mode_benchmark u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .func(func),
		.format_signature(format_signature), .eligible(eligible),
		.report_token(report_token), .full_copy(full_copy),
		.elapsed_time(elapsed_time), .packed_path(packed_path),
		.out_valid(out_valid), .out_stall(out_stall), .wants_packed(wants_packed),
		.benchmarking(benchmarking), .timing_token(timing_token),
		.phase_code(phase_code),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs; well above the slowest legal run.
	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Mostly back to back, sometimes a short pause, rarely a long one.
	function automatic int pick_gap();
		int r;
		if (!idle_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offer one word, hold it until it is taken, then log it with the tracker.
	// Entered and left at a falling edge.
	task automatic send_word(logic [1:0] fn, logic [SIG_W-1:0] fsig, logic elig,
	                         logic [GEN_W-1:0] rtok, logic full, logic [TIME_W-1:0] t,
	                         logic pp);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		func = fn;
		format_signature = fsig;
		eligible = elig;
		report_token = rtok;
		full_copy = full;
		elapsed_time = t;
		packed_path = pp;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		tracker.note_word(fn, fsig, elig, rtok, full, t, pp);
		@(negedge clk);
	endtask

	task automatic send_update(logic [SIG_W-1:0] fsig, logic elig);
		send_word(FN_UPDATE, fsig, elig, $urandom, $urandom, {$urandom, $urandom}, $urandom);
	endtask

	// A report carrying the live generation, so it is counted.
	task automatic send_good_report(logic [TIME_W-1:0] t);
		send_word(FN_REPORT, $urandom, $urandom, tracker.gen, 1'b1, t, $urandom);
	endtask

	// Occasional junk between the well-formed words of a run.
	task automatic maybe_noise();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			send_word(FN_QUERY, $urandom, $urandom, $urandom, $urandom,
			          {$urandom, $urandom}, $urandom);
		else if (r < 5)
			send_word(FN_REPORT, $urandom, $urandom, tracker.gen, 1'b0,
			          {$urandom, $urandom}, $urandom);
		else if (r < 7)
			send_word(FN_REPORT, $urandom, $urandom, $urandom, 1'b1,
			          {$urandom, $urandom}, $urandom);
		else if (r == 7)
			send_word(FN_REJECT, $urandom, $urandom, $urandom, $urandom,
			          {$urandom, $urandom}, $urandom);
	endtask

	function automatic logic [TIME_W-1:0] draw_time(logic [TIME_W-1:0] base,
	                                                logic [31:0] spread);
		// A few outliers land in the trimmed tails.
		if ($urandom_range(0, 49) == 0) return {$urandom, $urandom};
		return base + $urandom_range(0, spread);
	endfunction

	// One full benchmark: native warmup and samples, packed warmup and samples,
	// then the closing update that picks the winner.
	task automatic bench_run(logic [SIG_W-1:0] fsig, int warmups);
		logic [TIME_W-1:0] nat_base, pk_base;
		logic [31:0]       spread;
		longint unsigned   margin;
		case ($urandom_range(0, 2))
			0: nat_base = $urandom_range(1000, 200000);
			1: nat_base = {$urandom_range(0, 255), $urandom};
			default: nat_base = {$urandom_range(0, 65535), $urandom};
		endcase
		spread = $urandom_range(0, 5000);
		margin = nat_base / ((tracker.divisor_r == 0) ? 1 : tracker.divisor_r);
		if (margin < tracker.floor_r) margin = tracker.floor_r;
		// Packed lands faster, inside the margin or beyond it.
		case ($urandom_range(0, 2))
			0: pk_base = nat_base - (nat_base >> $urandom_range(1, 8));
			1: pk_base = nat_base + (margin >> 1);
			default: pk_base = nat_base + margin + $urandom_range(0, 20000) + spread;
		endcase
		send_update(fsig, 1'b1);
		for (int s = 0; s < 2; s++) begin
			repeat (warmups) begin
				send_good_report({$urandom, $urandom});
				maybe_noise();
			end
			send_update(fsig, 1'b1);
			repeat (SAMPLE_COUNT + $urandom_range(0, 2)) begin
				send_good_report(draw_time(s == 0 ? nat_base : pk_base, spread));
				maybe_noise();
			end
			send_update(fsig, 1'b1);
		end
		send_word(FN_QUERY, $urandom, $urandom, $urandom, $urandom, '0, 1'b1);
	endtask

	task automatic write_reg(logic idx, logic [31:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.set_reg(idx, data);
	endtask

	// Registers change only once every owed word has come back.
	task automatic drain();
		in_valid = 1'b0;
		while (tracker.owed.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// Receiver: checks at the rising edge, picks the next stall at the falling
	// edge. A hold request keeps it stalled for a long stretch.
	initial begin
		int hold_left;
		int r;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				tracker.check_word({wants_packed, benchmarking, timing_token, phase_code});
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1'b1;
			end else if (!idle_gaps) begin
				out_stall = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) out_stall = 1'b0;
				else if (r < 97) out_stall = 1'b1;
				else begin
					out_stall = 1'b1;
					hold_left = $urandom_range(10, 60);
				end
			end
		end
	end

	initial begin
		logic [SIG_W-1:0] sig_a;
		logic [31:0]      floors [5];
		logic [31:0]      divs [5];
		int               sent;
		tracker = new();
		hold_req = 1'b0;
		idle_gaps = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FN_QUERY;
		format_signature = '0;
		eligible = 1'b0;
		report_token = '0;
		full_copy = 1'b0;
		elapsed_time = '0;
		packed_path = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FLOOR;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: the disabled phase, an ineligible format, stale and partial
		// reports, the extremes of the timing field and a reject outside packed.
		send_word(FN_QUERY, '0, 1'b0, '0, 1'b0, '0, 1'b0);
		send_word(FN_REJECT, '1, 1'b1, '1, 1'b1, '1, 1'b1);
		send_word(FN_REPORT, '0, 1'b0, '0, 1'b1, '1, 1'b0);
		send_update('0, 1'b0);
		send_update('1, 1'b1);
		send_word(FN_REPORT, '0, 1'b0, tracker.gen + 1, 1'b1, '1, 1'b0);
		send_word(FN_REPORT, '0, 1'b0, tracker.gen, 1'b0, '1, 1'b0);
		send_update('1, 1'b1);
		repeat (5) send_good_report('0);
		send_word(FN_QUERY, '0, 1'b0, '0, 1'b0, '0, 1'b1);
		send_word(FN_QUERY, '0, 1'b0, '0, 1'b0, '0, 1'b0);
		send_update('1, 1'b1);
		send_good_report('1);
		send_good_report('0);
		send_good_report({16'h8000, 32'h0000_0001});
		send_word(FN_REJECT, '0, 1'b0, '0, 1'b0, '0, 1'b1);
		send_update('1, 1'b1);
		send_update(32'h1234_5678, 1'b0);
		send_word(FN_REPORT, '0, 1'b0, tracker.gen, 1'b1, '1, 1'b1);

		// The warmup counter saturates well past its threshold.
		drain();
		sig_a = $urandom;
		send_update(sig_a, 1'b1);
		repeat (260) send_good_report({$urandom, $urandom});
		send_update(sig_a, 1'b1);

		// Long receiver stall while words keep coming: the block backs up.
		hold_req = 1'b1;
		repeat (30) send_word(FN_QUERY, $urandom, $urandom, $urandom, $urandom,
		                      {$urandom, $urandom}, $urandom);

		// Margin settings, the extremes and a zero divisor among them.
		floors[0] = 32'd50000; divs[0] = 32'd20;
		floors[1] = 32'd0;     divs[1] = 32'd1;
		floors[2] = '1;        divs[2] = 32'd255;
		floors[3] = $urandom;  divs[3] = 32'd0;
		floors[4] = $urandom_range(0, 100000); divs[4] = $urandom_range(1, 255);
		sent = 0;
		for (int k = 0; sent < 700; k++) begin
			drain();
			write_reg(CFG_FLOOR, floors[k % 5]);
			write_reg(CFG_DIVISOR, divs[k % 5]);
			idle_gaps = (k % 3 != 2);
			bench_run($urandom, $urandom_range(WARMUP_COUNT, WARMUP_COUNT + 3));
			// Sometimes a packed stage is cut short by a reject or a new format.
			if ($urandom_range(0, 2) == 0) begin
				sig_a = $urandom;
				send_update(sig_a, 1'b1);
				repeat (WARMUP_COUNT) send_good_report({$urandom, $urandom});
				send_update(sig_a, 1'b1);
				repeat (SAMPLE_COUNT) send_good_report({$urandom, $urandom});
				send_update(sig_a, 1'b1);
				send_good_report({$urandom, $urandom});
				if ($urandom_range(0, 1)) send_word(FN_REJECT, '0, 1'b0, '0, 1'b0, '0, 1'b1);
				else send_update($urandom, $urandom);
				sent += 75;
			end
			sent += 150;
		end
		in_valid = 1'b0;
		idle_gaps = 1'b1;

		while (tracker.owed.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (tracker.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
